// File: rtl/tamsa_pkg.sv
package tamsa_pkg;

    localparam int NUM_AREAS = 2;
    localparam int SIZE_W    = 18;
    localparam int OFFSET_W  = 18;
    localparam int LEFT_W    = 19;
    localparam int ROUND_ADD = 3;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_mem_ctl;

endpackage

// File: rtl/tamsa_if.sv
interface tamsa_req_if;
    logic                           valid;
    logic                           ready;
    logic                           kind;
    logic                           area;
    logic [tamsa_pkg::SIZE_W-1:0]   size;
    logic [tamsa_pkg::OFFSET_W-1:0] offset;

    modport source (output valid, kind, area, size, offset, input ready);
    modport sink   (input valid, kind, area, size, offset, output ready);
endinterface

interface tamsa_rsp_if;
    logic                           valid;
    logic                           ready;
    logic                           ok;
    logic                           out_area;
    logic [tamsa_pkg::OFFSET_W-1:0] out_offset;
    logic [tamsa_pkg::LEFT_W-1:0]   bytes_left;

    modport source (output valid, ok, out_area, out_offset, bytes_left, input ready);
    modport sink   (input valid, ok, out_area, out_offset, bytes_left, output ready);
endinterface

// File: rtl/two_area_mark_stack_allocator_unit.sv
// channel  | port  | dir | beat
// ---------+-------+-----+----------------------------------------------
// request  | i_req | in  | kind, area, size, offset
// response | o_rsp | out | ok, out_area, out_offset, bytes_left
//
// Per request, the accept edge reads two marks from the mark memory and
// the compute step checks space, writes back one mark if granted and loads
// the response register. One request is in flight at a time.
// The compute step waits while a previous response is still held on o_rsp.
// Reset clears the per-entry valid bits of the mark memory at once, so no
// clearing pass follows reset; unwritten marks read as zero.
module two_area_mark_stack_allocator_unit #(
    parameter int AREA_BYTES = 262144,
    parameter int MARK_DEPTH = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tamsa_req_if.sink  i_req,
    tamsa_rsp_if.source o_rsp
);

    localparam int MW      = $clog2(AREA_BYTES);
    localparam int LW      = $clog2(AREA_BYTES + 1);
    localparam int IW      = $clog2(MARK_DEPTH);
    localparam int ENTRIES = tamsa_pkg::NUM_AREAS * MARK_DEPTH;
    localparam int AW      = $clog2(ENTRIES);
    localparam int RW      = tamsa_pkg::SIZE_W + 1;
    localparam int CW      = ((LW > RW) ? LW : RW) + 1;
    localparam int OW      = tamsa_pkg::OFFSET_W;
    localparam int BW      = tamsa_pkg::LEFT_W;
    localparam int SW      = tamsa_pkg::SIZE_W;

    localparam logic [IW-1:0] TOP_LAST = IW'(MARK_DEPTH - 1);
    localparam logic [LW-1:0] AREA_END = LW'(AREA_BYTES);
    localparam logic [RW-1:0] RND_ADD  = RW'(tamsa_pkg::ROUND_ADD);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    function automatic logic [IW-1:0] f_inc(input logic [IW-1:0] idx);
        return (idx == TOP_LAST) ? '0 : idx + IW'(1);
    endfunction

    function automatic logic [IW-1:0] f_dec(input logic [IW-1:0] idx);
        return (idx == '0) ? TOP_LAST : idx - IW'(1);
    endfunction

    function automatic logic [AW-1:0] f_addr(input logic a, input logic [IW-1:0] idx);
        logic [AW-1:0] base;
        base = a ? AW'(MARK_DEPTH) : '0;
        return base + AW'(idx);
    endfunction

    function automatic logic [LW-1:0] f_free(input logic [MW-1:0] m);
        logic [LW-1:0] ext;
        ext = LW'(m);
        return (ext >= AREA_END) ? '0 : AREA_END - ext;
    endfunction

    logic              r_state;
    logic              n_state;
    logic [IW-1:0]     r_top [tamsa_pkg::NUM_AREAS];
    logic [IW-1:0]     n_top [tamsa_pkg::NUM_AREAS];
    logic              r_kind;
    logic              r_area;
    logic [SW-1:0]     r_size;
    logic [OW-1:0]     r_offset;
    logic              r_out_valid;
    logic              r_ok;
    logic              r_out_area;
    logic [OW-1:0]     r_out_offset;
    logic [BW-1:0]     r_bytes_left;

    logic              w_acc;
    logic              w_fire;
    tamsa_pkg::t_mem_ctl w_ctl;
    logic [AW-1:0]     w_rd_addr_a;
    logic [AW-1:0]     w_rd_addr_b;
    logic [AW-1:0]     w_wr_addr;
    logic [MW-1:0]     w_rd_a;
    logic [MW-1:0]     w_rd_b;
    logic [RW-1:0]     w_round;
    logic [LW-1:0]     w_free_a;
    logic [LW-1:0]     w_free_b;
    logic              w_fit_a;
    logic              w_fit_b;
    logic              w_alloc;
    logic              w_alloc_ok;
    logic              w_free_ok;
    logic              w_dst_area;
    logic [MW-1:0]     w_base;
    logic [IW-1:0]     w_nt;
    logic [CW-1:0]     w_sum;
    logic [MW-1:0]     w_new_mark;
    logic [IW-1:0]     w_below;
    logic [LW-1:0]     w_left;

    assign w_acc  = i_req.valid && i_req.ready;
    assign w_fire = (r_state == S_EXEC) && (!r_out_valid || o_rsp.ready);

    assign i_req.ready = (r_state == S_IDLE);

    assign w_rd_addr_a = f_addr(i_req.area, r_top[i_req.area]);
    assign w_rd_addr_b = (i_req.kind == tamsa_pkg::KIND_ALLOC)
                       ? f_addr(~i_req.area, r_top[~i_req.area])
                       : f_addr(i_req.area, f_dec(r_top[i_req.area]));

    tamsa_mark_store #(
        .ENTRIES (ENTRIES),
        .W       (MW)
    ) u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .i_rd_addr_a (w_rd_addr_a),
        .i_rd_addr_b (w_rd_addr_b),
        .i_wr_addr   (w_wr_addr),
        .i_wr_data   (w_new_mark),
        .o_rd_data_a (w_rd_a),
        .o_rd_data_b (w_rd_b)
    );

    always_comb begin
        w_round    = (RW'(r_size) + RND_ADD) & ~RND_ADD;
        w_free_a   = f_free(w_rd_a);
        w_free_b   = f_free(w_rd_b);
        w_fit_a    = CW'(w_free_a) > CW'(w_round);
        w_fit_b    = CW'(w_free_b) > CW'(w_round);
        w_alloc    = (r_kind == tamsa_pkg::KIND_ALLOC);
        w_alloc_ok = w_alloc && (w_fit_a || w_fit_b);
        w_dst_area = w_fit_a ? r_area : ~r_area;
        w_base     = w_fit_a ? w_rd_a : w_rd_b;
        w_nt       = f_inc(r_top[w_dst_area]);
        w_sum      = CW'(w_base) + CW'(w_round);
        w_new_mark = w_sum[MW-1:0];
        w_below    = f_dec(r_top[r_area]);
        w_free_ok  = !w_alloc && (CW'(w_rd_b) == CW'(r_offset));
        w_wr_addr  = f_addr(w_dst_area, w_nt);

        if (w_alloc && w_fit_a) begin
            w_left = AREA_END - LW'(w_new_mark);
        end else if (w_free_ok) begin
            w_left = w_free_b;
        end else begin
            w_left = w_free_a;
        end

        w_ctl.rd_en = w_acc;
        w_ctl.wr_en = w_fire && w_alloc_ok;
    end

    always_comb begin
        n_state = r_state;
        n_top   = r_top;
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_fire) begin
                    n_state = S_IDLE;
                    if (w_alloc_ok) begin
                        n_top[w_dst_area] = w_nt;
                    end else if (w_free_ok) begin
                        n_top[r_area] = w_below;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_top       <= '{default: '0};
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_top   <= n_top;
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_kind   <= i_req.kind;
            r_area   <= i_req.area;
            r_size   <= i_req.size;
            r_offset <= i_req.offset;
        end
        if (w_fire) begin
            r_ok         <= w_alloc ? w_alloc_ok : w_free_ok;
            r_out_area   <= w_alloc_ok ? w_dst_area : 1'b0;
            r_out_offset <= w_alloc_ok ? OW'(w_base) : '0;
            r_bytes_left <= BW'(w_left);
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.ok         = r_ok;
    assign o_rsp.out_area   = r_out_area;
    assign o_rsp.out_offset = r_out_offset;
    assign o_rsp.bytes_left = r_bytes_left;

`ifndef NO_ASSERTIONS
    a_acc_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> (r_state == S_EXEC) && $stable(r_top[0]) && $stable(r_top[1]))
        else $error("accepted request did not enter compute step with tops held");

    a_fail_keeps_tops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_alloc && !w_alloc_ok) |=> $stable(r_top[0]) && $stable(r_top[1]))
        else $error("failed allocation moved a top index");

    a_pop_moves_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_free_ok) |=>
            (r_top[0] != $past(r_top[0])) || (r_top[1] != $past(r_top[1])))
        else $error("successful free left top indices unchanged");

    a_fire_loads_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> r_out_valid && (r_state == S_IDLE))
        else $error("compute step did not produce a response");
`endif

endmodule

// File: rtl/tamsa_mark_store.sv
module tamsa_mark_store #(
    parameter int ENTRIES = 16,
    parameter int W       = 18
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  tamsa_pkg::t_mem_ctl          i_ctl,
    input  logic [$clog2(ENTRIES)-1:0]   i_rd_addr_a,
    input  logic [$clog2(ENTRIES)-1:0]   i_rd_addr_b,
    input  logic [$clog2(ENTRIES)-1:0]   i_wr_addr,
    input  logic [W-1:0]                 i_wr_data,
    output logic [W-1:0]                 o_rd_data_a,
    output logic [W-1:0]                 o_rd_data_b
);

    logic [W-1:0]       r_mem [ENTRIES];
    logic [ENTRIES-1:0] r_valid;
    logic [W-1:0]       r_rd_a;
    logic [W-1:0]       r_rd_b;
    logic               r_rd_va;
    logic               r_rd_vb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_ctl.wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_a  <= r_mem[i_rd_addr_a];
            r_rd_b  <= r_mem[i_rd_addr_b];
            r_rd_va <= r_valid[i_rd_addr_a];
            r_rd_vb <= r_valid[i_rd_addr_b];
        end
    end

    assign o_rd_data_a = r_rd_va ? r_rd_a : '0;
    assign o_rd_data_b = r_rd_vb ? r_rd_b : '0;

endmodule

// File: verif/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int AREA_BYTES   = 262144;
    localparam int MARK_DEPTH   = 8;
    localparam int SLOT_W       = $clog2(MARK_DEPTH);
    localparam int N_DIR        = 25;
    localparam int N_RANDOM     = 1500;
    localparam int N_ITEMS      = N_DIR + N_RANDOM;
    localparam int PHASE_LEN    = N_RANDOM / 4;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic                           kind;
        logic                           area;
        logic [tamsa_pkg::SIZE_W-1:0]   size;
        logic [tamsa_pkg::OFFSET_W-1:0] offset;
    } t_alloc_req;

    typedef struct packed {
        logic                           ok;
        logic                           out_area;
        logic [tamsa_pkg::OFFSET_W-1:0] out_offset;
        logic [tamsa_pkg::LEFT_W-1:0]   bytes_left;
    } t_alloc_rsp;

    typedef struct packed {
        t_alloc_req req;
        logic       typed;
        t_alloc_rsp rsp;
    } t_dir_row;

    localparam logic [tamsa_pkg::LEFT_W-1:0] FULL   = 19'd262144;
    localparam t_alloc_rsp                   NO_RSP = '0;

    localparam t_dir_row DIR_ROWS [N_DIR] = '{
        {tamsa_pkg::KIND_FREE,  1'b0, 18'd0,      18'd5,      1'b1, 1'b0, 1'b0, 18'd0, FULL},
        {tamsa_pkg::KIND_FREE,  1'b0, 18'h3FFFF,  18'h3FFFF,  1'b1, 1'b0, 1'b0, 18'd0, FULL},
        {tamsa_pkg::KIND_ALLOC, 1'b0, 18'd0,      18'h3FFFF,  1'b1, 1'b1, 1'b0, 18'd0, FULL},
        {tamsa_pkg::KIND_ALLOC, 1'b0, 18'd1,      18'd0,      1'b1, 1'b1, 1'b0, 18'd0,
         19'd262140},
        {tamsa_pkg::KIND_ALLOC, 1'b1, 18'h3FFFF,  18'd0,      1'b1, 1'b0, 1'b0, 18'd0, FULL},
        {tamsa_pkg::KIND_ALLOC, 1'b1, 18'd262140, 18'd0,      1'b1, 1'b1, 1'b1, 18'd0, 19'd4},
        {tamsa_pkg::KIND_ALLOC, 1'b1, 18'd3,      18'd0,      1'b1, 1'b1, 1'b0, 18'd4, 19'd4},
        {tamsa_pkg::KIND_ALLOC, 1'b0, 18'd262131, 18'h15555,  1'b0, NO_RSP},
        {tamsa_pkg::KIND_FREE,  1'b0, 18'h2AAAA,  18'd4,      1'b0, NO_RSP},
        {tamsa_pkg::KIND_FREE,  1'b0, 18'd0,      18'd8,      1'b0, NO_RSP},
        {tamsa_pkg::KIND_FREE,  1'b1, 18'd0,      18'd0,      1'b1, 1'b1, 1'b0, 18'd0, FULL},
        {tamsa_pkg::KIND_FREE,  1'b1, 18'd0,      18'd0,      1'b1, 1'b1, 1'b0, 18'd0, FULL},
        {tamsa_pkg::KIND_ALLOC, 1'b1, 18'd8,      18'h2AAAA,  1'b0, NO_RSP},
        {tamsa_pkg::KIND_ALLOC, 1'b1, 18'd7,      18'h15555,  1'b0, NO_RSP},
        {tamsa_pkg::KIND_ALLOC, 1'b1, 18'd5,      18'h2AAAA,  1'b0, NO_RSP},
        {tamsa_pkg::KIND_ALLOC, 1'b1, 18'd6,      18'h15555,  1'b0, NO_RSP},
        {tamsa_pkg::KIND_ALLOC, 1'b1, 18'd8,      18'd0,      1'b0, NO_RSP},
        {tamsa_pkg::KIND_ALLOC, 1'b1, 18'd8,      18'd0,      1'b0, NO_RSP},
        {tamsa_pkg::KIND_ALLOC, 1'b1, 18'd8,      18'd0,      1'b0, NO_RSP},
        {tamsa_pkg::KIND_ALLOC, 1'b1, 18'd8,      18'd0,      1'b0, NO_RSP},
        {tamsa_pkg::KIND_ALLOC, 1'b1, 18'd8,      18'd0,      1'b0, NO_RSP},
        {tamsa_pkg::KIND_ALLOC, 1'b1, 18'd8,      18'd0,      1'b0, NO_RSP},
        {tamsa_pkg::KIND_FREE,  1'b1, 18'd0,      18'd80,     1'b0, NO_RSP},
        {tamsa_pkg::KIND_FREE,  1'b1, 18'd0,      18'd72,     1'b0, NO_RSP},
        {tamsa_pkg::KIND_FREE,  1'b1, 18'd0,      18'd64,     1'b0, NO_RSP}
    };

    logic i_clk;
    logic i_rst_n;

    tamsa_req_if req_if ();
    tamsa_rsp_if rsp_if ();

    two_area_mark_stack_allocator_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    logic [tamsa_pkg::OFFSET_W-1:0] area_marks [tamsa_pkg::NUM_AREAS][MARK_DEPTH];
    logic [SLOT_W-1:0]              top_slot   [tamsa_pkg::NUM_AREAS];
    t_alloc_rsp                     awaited_rsps [$];

    int accepted_cnt   = 0;
    int recv_stall_pct = 0;
    bit hold_active    = 1'b0;
    int cycle_cnt      = 0;
    int fault_cnt      = 0;
    int checked_cnt    = 0;
    int alloc_ok_cnt   = 0;
    int alloc_fail_cnt = 0;
    int free_ok_cnt    = 0;
    int free_fail_cnt  = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int space_left(int a);
        int m;
        m = int'(area_marks[a][top_slot[a]]);
        return (m >= AREA_BYTES) ? 0 : AREA_BYTES - m;
    endfunction

    function automatic t_alloc_rsp step_mark_stacks(t_alloc_req r);
        t_alloc_rsp        rsp;
        int                need;
        int                a;
        logic [SLOT_W-1:0] slot;
        rsp = '0;
        if (r.kind == tamsa_pkg::KIND_ALLOC) begin
            need = (int'(r.size) + tamsa_pkg::ROUND_ADD) & ~tamsa_pkg::ROUND_ADD;
            a    = r.area;
            for (int t = 0; t < tamsa_pkg::NUM_AREAS; t++) begin
                if (!rsp.ok && space_left(a) > need) begin
                    slot               = top_slot[a] + 1'b1;
                    rsp.ok             = 1'b1;
                    rsp.out_area       = a[0];
                    rsp.out_offset     = area_marks[a][top_slot[a]];
                    area_marks[a][slot] = area_marks[a][top_slot[a]]
                                        + need[tamsa_pkg::OFFSET_W-1:0];
                    top_slot[a]        = slot;
                end
                a = (a + 1) % tamsa_pkg::NUM_AREAS;
            end
        end else begin
            slot = top_slot[r.area] - 1'b1;
            if (area_marks[r.area][slot] == r.offset) begin
                rsp.ok           = 1'b1;
                top_slot[r.area] = slot;
            end
        end
        rsp.bytes_left = tamsa_pkg::LEFT_W'(space_left(r.area));
        return rsp;
    endfunction

    // mostly well-formed traffic: small, medium and near-full allocations, pops of the top block
    function automatic t_alloc_req random_request();
        t_alloc_req        r;
        int                pick;
        int                room;
        logic [SLOT_W-1:0] slot;
        r.kind   = ($urandom_range(99) < 55) ? tamsa_pkg::KIND_ALLOC : tamsa_pkg::KIND_FREE;
        r.area   = 1'($urandom_range(1));
        r.size   = tamsa_pkg::SIZE_W'($urandom);
        r.offset = tamsa_pkg::OFFSET_W'($urandom);
        pick     = $urandom_range(99);
        if (r.kind == tamsa_pkg::KIND_ALLOC) begin
            if (pick < 45) begin
                r.size = tamsa_pkg::SIZE_W'($urandom_range(255));
            end else if (pick < 75) begin
                r.size = tamsa_pkg::SIZE_W'($urandom_range(32767));
            end else if (pick >= 90) begin
                room = space_left(r.area) - int'($urandom_range(5));
                if (room < 0) room = 0;
                if (room > 2**tamsa_pkg::SIZE_W - 1) room = 2**tamsa_pkg::SIZE_W - 1;
                r.size = tamsa_pkg::SIZE_W'(room);
            end
        end else if (pick < 75) begin
            slot     = top_slot[r.area] - 1'b1;
            r.offset = area_marks[r.area][slot];
        end
        return r;
    endfunction

    task automatic drive_requests();
        t_alloc_req cur;
        t_alloc_rsp want;
        int         n;
        int         row;
        int         phase;
        int         idle_pct;
        bit         busy;
        n    = 0;
        row  = -1;
        busy = 1'b0;
        while (n < N_ITEMS || busy) begin
            @(posedge i_clk);
            if (busy && req_if.ready) begin
                want = step_mark_stacks(cur);
                if (row >= 0 && DIR_ROWS[row].typed) want = DIR_ROWS[row].rsp;
                if (cur.kind == tamsa_pkg::KIND_ALLOC) begin
                    if (want.ok) alloc_ok_cnt++; else alloc_fail_cnt++;
                end else begin
                    if (want.ok) free_ok_cnt++; else free_fail_cnt++;
                end
                awaited_rsps.push_back(want);
                accepted_cnt <= accepted_cnt + 1;
                busy = 1'b0;
            end
            if (!busy) begin
                phase = (n < N_DIR) ? -1 : (n - N_DIR) / PHASE_LEN;
                case (phase)
                    1:       idle_pct = 73;
                    3:       idle_pct = 21;
                    default: idle_pct = 0;
                endcase
                recv_stall_pct <= (phase == 2) ? 73 : (phase == 3) ? 21 : 0;
                if (n >= N_ITEMS) begin
                    req_if.valid <= 1'b0;
                end else if (n >= N_DIR && (n - N_DIR) % PHASE_LEN == 0
                             && awaited_rsps.size() != 0) begin
                    // drain before each new phase
                    req_if.valid <= 1'b0;
                end else if ($urandom_range(99) < idle_pct) begin
                    req_if.valid <= 1'b0;
                end else begin
                    if (n < N_DIR) begin
                        row = n;
                        cur = DIR_ROWS[n].req;
                    end else begin
                        row = -1;
                        cur = random_request();
                    end
                    req_if.valid  <= 1'b1;
                    req_if.kind   <= cur.kind;
                    req_if.area   <= cur.area;
                    req_if.size   <= cur.size;
                    req_if.offset <= cur.offset;
                    busy = 1'b1;
                    n++;
                end
            end
        end
    endtask

    task automatic check_response();
        t_alloc_rsp got;
        t_alloc_rsp want;
        got = {rsp_if.ok, rsp_if.out_area, rsp_if.out_offset, rsp_if.bytes_left};
        if (awaited_rsps.size() == 0) begin
            fault_cnt++;
            if (fault_cnt <= MAX_REPORTS)
                $display("%0t: beat with none outstanding: ok=%0d area=%0d off=%0d left=%0d",
                         $realtime, got.ok, got.out_area, got.out_offset, got.bytes_left);
        end else begin
            want = awaited_rsps.pop_front();
            checked_cnt++;
            if (got.ok !== want.ok || got.out_area !== want.out_area
                || got.out_offset !== want.out_offset || got.bytes_left !== want.bytes_left) begin
                fault_cnt++;
                if (fault_cnt <= MAX_REPORTS) begin
                    $display("%0t: response %0d exp ok=%0d area=%0d off=%0d left=%0d",
                             $realtime, checked_cnt, want.ok, want.out_area, want.out_offset,
                             want.bytes_left);
                    $display("%0t: response %0d got ok=%0d area=%0d off=%0d left=%0d",
                             $realtime, checked_cnt, got.ok, got.out_area, got.out_offset,
                             got.bytes_left);
                end
            end
        end
    endtask

    initial begin
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rsp_if.valid && rsp_if.ready) check_response();
            rsp_if.ready <= !hold_active && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // block the response side while requests keep coming
    initial begin
        wait (accepted_cnt >= N_DIR + 60);
        @(posedge i_clk);
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_active <= 1'b0;
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("timeout after %0d cycles, %0d responses outstanding", cycle_cnt,
                 awaited_rsps.size());
        $display("FAIL two_area_mark_stack_allocator_unit");
        $finish;
    end

    initial begin
        for (int a = 0; a < tamsa_pkg::NUM_AREAS; a++) begin
            top_slot[a] = '0;
            for (int i = 0; i < MARK_DEPTH; i++) area_marks[a][i] = '0;
        end
        i_rst_n       <= 1'b0;
        req_if.valid  <= 1'b0;
        req_if.kind   <= tamsa_pkg::KIND_ALLOC;
        req_if.area   <= 1'b0;
        req_if.size   <= '0;
        req_if.offset <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        drive_requests();
        while (awaited_rsps.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("%0d requests: %0d allocations granted, %0d refused, %0d pops, %0d bad pops",
                 accepted_cnt, alloc_ok_cnt, alloc_fail_cnt, free_ok_cnt, free_fail_cnt);
        $display("%0d responses checked across four idle/stall phases, %0d-cycle hold, %0d errors",
                 checked_cnt, HOLD_CYCLES, fault_cnt);
        if (fault_cnt == 0) begin
            $display("PASS two_area_mark_stack_allocator_unit");
        end else begin
            $display("FAIL two_area_mark_stack_allocator_unit");
        end
        $finish;
    end

endmodule

// File: two_area_mark_stack_allocator_unit.f
rtl/tamsa_pkg.sv
rtl/tamsa_if.sv
rtl/tamsa_mark_store.sv
rtl/two_area_mark_stack_allocator_unit.sv
verif/tb.sv
